FILE: src/ats_pkg.sv
// Shared types, codes and the value-type classifier for the aux tag scanner.
// No dependencies; every other file uses this package by scoped names.
package ats_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_FOUND      = 3'd0,
      ST_END        = 3'd1,
      ST_TRUNC      = 3'd2,
      ST_UNTERM     = 3'd3,
      ST_BAD_TYPE   = 3'd4,
      ST_BAD_ELEM   = 3'd5
   } status_type;

   // Value class: fixed sizes are the byte count itself
   localparam logic [3:0] CLASS_BAD  = 4'd0;
   localparam logic [3:0] CLASS_SZ1  = 4'd1;
   localparam logic [3:0] CLASS_SZ2  = 4'd2;
   localparam logic [3:0] CLASS_SZ4  = 4'd4;
   localparam logic [3:0] CLASS_STR  = 4'd8;
   localparam logic [3:0] CLASS_ARR  = 4'd9;

   // Configuration register indexes
   localparam logic CSR_TAG_FIRST  = 1'b0;
   localparam logic CSR_TAG_SECOND = 1'b1;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
   } tag_type;

   typedef struct packed {
      logic [7:0] vtype;
      logic [31:0] offset;
      status_type status;
   } result_type;

   function automatic logic [3:0] classify(input logic [7:0] t);
      logic [3:0] c;
      case (t)
         8'h41, 8'h63, 8'h43:        c = CLASS_SZ1; // A c C
         8'h73, 8'h53:               c = CLASS_SZ2; // s S
         8'h69, 8'h49, 8'h66:        c = CLASS_SZ4; // i I f
         8'h5A, 8'h48:               c = CLASS_STR; // Z H
         8'h42:                      c = CLASS_ARR; // B
         default:                    c = CLASS_BAD;
      endcase
      return c;
   endfunction

endpackage

FILE: src/ats_scan_core.sv
// Per-record tag walk: scanner state registers and the one-byte step logic.
// Depends on ats_pkg (classifier, status codes, result and tag structs).
module ats_scan_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         byte_val,
   input  logic               last,
   input  ats_pkg::tag_type   tag,
   output logic               emit,
   output ats_pkg::result_type result
);

   typedef enum logic [1:0] {
      MODE_HEADER,
      MODE_SKIP,
      MODE_STRING,
      MODE_ARRHDR
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hphase_ff, hphase_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] start_ff, start_in;
   logic [34:0] skip_ff, skip_in;
   logic [31:0] strings_ff, strings_in;
   logic [2:0]  aphase_ff, aphase_in;
   logic [3:0]  kind_ff, kind_in;
   logic [31:0] count_ff, count_in;
   logic        given_ff, given_in;

   logic [3:0]  cls;
   logic [34:0] skip_dec;
   logic [31:0] count_full;
   logic [34:0] arr_bytes;
   logic [1:0]  lane;

   always_comb begin
      cls        = ats_pkg::classify(byte_val);
      skip_dec   = (skip_ff != '0) ? skip_ff - 35'd1 : skip_ff;
      count_full = {byte_val, count_ff[23:0]};
      lane       = aphase_ff[1:0] - 2'd1;
      case (kind_ff)
         ats_pkg::CLASS_SZ2: arr_bytes = {2'b00, count_full, 1'b0};
         ats_pkg::CLASS_SZ4: arr_bytes = {1'b0, count_full, 2'b00};
         default:            arr_bytes = {3'b000, count_full};
      endcase

      mode_in    = mode_ff;
      hphase_in  = hphase_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      pos_in     = pos_ff + 32'd1;
      start_in   = start_ff;
      skip_in    = skip_ff;
      strings_in = strings_ff;
      aphase_in  = aphase_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      given_in   = given_ff;
      emit       = 1'b0;
      result.status = ats_pkg::ST_END;
      result.offset = '0;
      result.vtype  = '0;

      if (!given_ff) begin
         case (mode_ff)
            MODE_HEADER: begin
               if (hphase_ff == 2'd0) begin
                  first_in  = byte_val;
                  start_in  = pos_ff;
                  hphase_in = 2'd1;
                  emit      = last;
               end else if (hphase_ff == 2'd1) begin
                  second_in = byte_val;
                  hphase_in = 2'd2;
                  emit      = last;
               end else begin
                  hphase_in = 2'd0;
                  if (first_ff == tag.first && second_ff == tag.second) begin
                     emit          = 1'b1;
                     result.status = ats_pkg::ST_FOUND;
                     result.offset = start_ff;
                     result.vtype  = byte_val;
                  end else if (cls == ats_pkg::CLASS_BAD) begin
                     emit          = 1'b1;
                     result.status = ats_pkg::ST_BAD_TYPE;
                  end else if (cls == ats_pkg::CLASS_STR) begin
                     if (last) begin
                        emit          = 1'b1;
                        result.status = ats_pkg::ST_UNTERM;
                     end else begin
                        mode_in    = MODE_STRING;
                        strings_in = 32'd1;
                     end
                  end else if (last) begin
                     emit          = 1'b1;
                     result.status = ats_pkg::ST_TRUNC;
                  end else if (cls == ats_pkg::CLASS_ARR) begin
                     mode_in   = MODE_ARRHDR;
                     aphase_in = 3'd0;
                     count_in  = '0;
                  end else begin
                     mode_in = MODE_SKIP;
                     skip_in = {31'd0, cls};
                  end
               end
            end
            MODE_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  mode_in = MODE_HEADER;
                  emit    = last;
               end else begin
                  emit          = last;
                  result.status = ats_pkg::ST_TRUNC;
               end
            end
            MODE_STRING: begin
               emit          = last;
               result.status = ats_pkg::ST_UNTERM;
               if (byte_val == 8'd0) begin
                  strings_in = (strings_ff != '0) ? strings_ff - 32'd1 : strings_ff;
                  if (strings_in == '0) begin
                     mode_in       = MODE_HEADER;
                     result.status = ats_pkg::ST_END;
                  end
               end
            end
            MODE_ARRHDR: begin
               if (aphase_ff == 3'd0) begin
                  kind_in       = cls;
                  aphase_in     = 3'd1;
                  emit          = last;
                  result.status = ats_pkg::ST_TRUNC;
               end else if (aphase_ff < 3'd4) begin
                  count_in      = count_ff | ({24'd0, byte_val} << {lane, 3'b000});
                  aphase_in     = aphase_ff + 3'd1;
                  emit          = last;
                  result.status = ats_pkg::ST_TRUNC;
               end else begin
                  // fifth header byte: count complete, element type checked now
                  count_in  = count_full;
                  aphase_in = 3'd0;
                  if (kind_ff == ats_pkg::CLASS_BAD || kind_ff == ats_pkg::CLASS_ARR) begin
                     emit          = 1'b1;
                     result.status = ats_pkg::ST_BAD_ELEM;
                  end else if (kind_ff == ats_pkg::CLASS_STR) begin
                     if (count_full == '0) begin
                        mode_in = MODE_HEADER;
                        emit    = last;
                     end else if (last) begin
                        emit          = 1'b1;
                        result.status = ats_pkg::ST_UNTERM;
                     end else begin
                        mode_in    = MODE_STRING;
                        strings_in = count_full;
                     end
                  end else begin
                     skip_in = arr_bytes;
                     if (arr_bytes == '0) begin
                        mode_in = MODE_HEADER;
                        emit    = last;
                     end else if (last) begin
                        emit          = 1'b1;
                        result.status = ats_pkg::ST_TRUNC;
                     end else begin
                        mode_in = MODE_SKIP;
                     end
                  end
               end
            end
            default: begin
               mode_in = MODE_HEADER;
            end
         endcase
      end

      if (emit) begin
         given_in = 1'b1;
      end

      if (last) begin
         mode_in    = MODE_HEADER;
         hphase_in  = '0;
         first_in   = '0;
         second_in  = '0;
         pos_in     = '0;
         start_in   = '0;
         skip_in    = '0;
         strings_in = '0;
         aphase_in  = '0;
         kind_in    = '0;
         count_in   = '0;
         given_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_HEADER;
         hphase_ff  <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
         pos_ff     <= '0;
         start_ff   <= '0;
         skip_ff    <= '0;
         strings_ff <= '0;
         aphase_ff  <= '0;
         kind_ff    <= '0;
         count_ff   <= '0;
         given_ff   <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         hphase_ff  <= hphase_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         pos_ff     <= pos_in;
         start_ff   <= start_in;
         skip_ff    <= skip_in;
         strings_ff <= strings_in;
         aphase_ff  <= aphase_in;
         kind_ff    <= kind_in;
         count_ff   <= count_in;
         given_ff   <= given_in;
      end
   end

endmodule

FILE: src/ats_out_fifo.sv
// Two-entry result buffer between the scan step and the result channel.
// Depends on ats_pkg (result struct).
module ats_out_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ats_pkg::result_type push_data,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ats_pkg::result_type pop_data
);

   ats_pkg::result_type entry_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rptr_ff];
   assign pop       = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

FILE: src/aux_tag_scanner.sv
// Top level of the aux tag scanner: input register, tag registers, ports.
// Depends on ats_pkg, ats_scan_core and ats_out_fifo.
//
// Usage: stream one record's auxiliary bytes on req_ (one byte per beat,
// req_tlast on the final byte). Each record gives at most one beat on rsp_:
// status, the tag's byte offset and its type byte. Bytes after the result
// beat up to req_tlast are consumed and dropped.
// The tag searched for is set through csr_ (index 0 first character,
// index 1 second); write it only while no record is in flight.
// Throughput: one byte per cycle while the result buffer is not full; each byte is a
// single state update of the scan core between the input register and the result buffer.
// Path: input register, then result buffer, which drives the result beat on rsp_.
// Stall: a two-entry result buffer holds results while rsp_tready is low;
// when it is full the input register holds and req_tready drops.
// Reset: clears scan state, buffers and both tag characters to zero.
module aux_tag_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] aux_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [2:0] status, [34:3] tag_offset, [42:35] value_type
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   ats_pkg::tag_type   tag_ff;
   logic               step;
   logic               emit;
   logic               fifo_full;
   ats_pkg::result_type result;
   ats_pkg::result_type out_data;

   assign step       = in_valid_ff && !fifo_full;
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         tag_ff      <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (csr_valid) begin
            case (csr_index)
               ats_pkg::CSR_TAG_FIRST:  tag_ff.first  <= csr_data;
               ats_pkg::CSR_TAG_SECOND: tag_ff.second <= csr_data;
               default:                 tag_ff        <= tag_ff;
            endcase
         end
      end
   end

   ats_scan_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .byte_val (in_byte_ff),
      .last     (in_last_ff),
      .tag      (tag_ff),
      .emit     (emit),
      .result   (result)
   );

   ats_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (step && emit),
      .push_data (result),
      .full      (fifo_full),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (out_data)
   );

   assign rsp_tdata = {5'd0, out_data.vtype, out_data.offset, out_data.status};

endmodule
